>>> hdl/toroidal_life_generation_top_macros.svh
// Assertion helpers for the checker file of the life block.
`ifndef TOROIDAL_LIFE_GENERATION_TOP_MACROS_SVH
`define TOROIDAL_LIFE_GENERATION_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define TLG_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define TLG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tlg_pkg.sv
package tlg_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int CFG_W    = 7;
    localparam int CNT_W    = 4;
    localparam int FUNC_W   = 2;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEEK,
        S_UPROW,
        S_GEN,
        S_FINISH
    } state_t;

    // Old values of one column at the row above, the current row and the row below.
    typedef struct packed {
        logic up;
        logic cur;
        logic down;
    } tri_t;

    // Controls broadcast by the sequencer to every column cell.
    typedef struct packed {
        logic load_up;
        logic load_first;
        logic update;
        logic down_first;
        logic down_cur;
        logic wr_en;
        logic wr_val;
    } ctl_t;

    // Saturates a size register into 1..limit.
    function automatic logic [CFG_W-1:0] sat_size(input logic [CFG_W-1:0] r, input int limit);
        logic [CFG_W-1:0] s;
        if (r == '0) begin
            s = CFG_W'(1);
        end else if (int'(r) > limit) begin
            s = CFG_W'(limit);
        end else begin
            s = r;
        end
        return s;
    endfunction

endpackage

>>> hdl/tlg_cell.sv
// One grid column: a rotating line of row bits plus the saved rows used by a step.
module tlg_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  tlg_pkg::ctl_t ctl,
    input  logic          active,
    input  logic          sel,
    input  tlg_pkg::tri_t nbr_l,
    input  tlg_pkg::tri_t nbr_r,
    output tlg_pkg::tri_t own
);

    logic [tlg_pkg::MAX_ROWS-1:0] line_reg;
    logic [tlg_pkg::MAX_ROWS-1:0] line_next;
    logic                         up_reg;
    logic                         up_next;
    logic                         first_reg;
    logic                         first_next;
    logic [tlg_pkg::CNT_W-1:0]    count;
    logic                         new_bit;
    logic                         wb;

    always_comb
    begin
        own.up   = up_reg;
        own.cur  = line_reg[0];
        own.down = ctl.down_cur ? line_reg[0] : (ctl.down_first ? first_reg : line_reg[1]);

        count = tlg_pkg::CNT_W'(nbr_l.up)   + tlg_pkg::CNT_W'(up_reg)   + tlg_pkg::CNT_W'(nbr_r.up)
              + tlg_pkg::CNT_W'(nbr_l.down) + tlg_pkg::CNT_W'(own.down) + tlg_pkg::CNT_W'(nbr_r.down)
              + tlg_pkg::CNT_W'(nbr_l.cur)  + tlg_pkg::CNT_W'(nbr_r.cur);

        if (line_reg[0]) begin
            new_bit = (count == tlg_pkg::CNT_W'(2)) || (count == tlg_pkg::CNT_W'(3));
        end else begin
            new_bit = (count == tlg_pkg::CNT_W'(3));
        end

        if (ctl.update && active) begin
            wb = new_bit;
        end else if (ctl.wr_en && sel) begin
            wb = ctl.wr_val;
        end else begin
            wb = line_reg[0];
        end

        // The line rotates every cycle; the head bit is written back at the tail.
        line_next  = {wb, line_reg[tlg_pkg::MAX_ROWS-1:1]};
        up_next    = ctl.load_up ? line_reg[0] : up_reg;
        first_next = ctl.load_first ? line_reg[0] : first_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            line_reg  <= '0;
            up_reg    <= 1'b0;
            first_reg <= 1'b0;
        end else begin
            line_reg  <= line_next;
            up_reg    <= up_next;
            first_reg <= first_next;
        end
    end

endmodule

>>> hdl/toroidal_life_generation_top.sv
// Toroidal B3/S23 life grid built as a row of column cells. Each cell holds one column of
// MAX_ROWS bits in a line that rotates by one row every clock, so all columns show the same
// row at their head, and a shared counter tracks which row that is. A write or a read waits
// for the addressed row to reach the head. A generation waits for the last active row to
// pass the head (it is saved as the row above row 0), then for row 0, then updates one row
// per cycle with every active column cell working in parallel from its own and its two
// neighbors' saved bits. Unused operation code 3 and cells outside the active area skip
// the wait for the head. One item is worked on at a time; a finished result sits in an
// output register so the next item can be accepted while it waits. The grid is cleared
// by reset.
module toroidal_life_generation_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [tlg_pkg::FUNC_W-1:0]   func,
    input  logic [tlg_pkg::ROW_W-1:0]    row,
    input  logic [tlg_pkg::COL_W-1:0]    col,
    input  logic                         value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         alive,
    output logic                         done_res,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [tlg_pkg::CFG_W-1:0]    cfg_data
);

    tlg_pkg::state_t               state_reg, state_next;
    logic [tlg_pkg::ROW_W-1:0]     head_reg, head_next;
    logic [tlg_pkg::FUNC_W-1:0]    op_reg, op_next;
    logic [tlg_pkg::ROW_W-1:0]     row_reg, row_next;
    logic [tlg_pkg::COL_W-1:0]     tcol_reg, tcol_next;
    logic                          val_reg, val_next;
    logic                          started_reg, started_next;
    logic                          res_alive_reg, res_alive_next;
    logic                          res_done_reg, res_done_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          alive_reg, alive_next;
    logic                          done_reg, done_next;
    logic [tlg_pkg::CFG_W-1:0]     rows_in_use_reg, rows_in_use_next;
    logic [tlg_pkg::CFG_W-1:0]     cols_in_use_reg, cols_in_use_next;

    logic [tlg_pkg::CFG_W-1:0]     nr;
    logic [tlg_pkg::CFG_W-1:0]     nc;
    logic [tlg_pkg::COL_W-1:0]     last_col;
    logic                          at_target;
    logic                          at_last_row;
    logic                          at_row0;
    logic                          in_area;
    logic                          proc;
    logic                          slot_free;
    tlg_pkg::ctl_t                 ctl;
    tlg_pkg::tri_t                 cell_tri [tlg_pkg::MAX_COLS];
    logic [tlg_pkg::MAX_COLS-1:0]  cur_vec;

    // Active sizes as used; the registers keep what was written.
    assign nr       = tlg_pkg::sat_size(rows_in_use_reg, tlg_pkg::MAX_ROWS);
    assign nc       = tlg_pkg::sat_size(cols_in_use_reg, tlg_pkg::MAX_COLS);
    assign last_col = tlg_pkg::COL_W'(int'(nc) - 1);

    assign at_target   = (head_reg == row_reg);
    assign at_last_row = (int'(head_reg) == int'(nr) - 1);
    assign at_row0     = (head_reg == '0);
    assign in_area     = (int'(row) < int'(nr)) && (int'(col) < int'(nc));
    assign proc        = (state_reg == tlg_pkg::S_GEN) && (started_reg || at_row0);
    assign slot_free   = !out_valid_reg || !out_stall;

    assign in_stall  = (state_reg != tlg_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign alive     = alive_reg;
    assign done_res  = done_reg;

    // Row of column cells. Column wrap: cell 0 sees the last active column on its left,
    // and the last active column sees cell 0 on its right. Columns beyond the active area
    // hold their bits through a step.
    for (genvar c = 0; c < tlg_pkg::MAX_COLS; c++)
    begin : g_col
        tlg_pkg::tri_t left_nbr;
        tlg_pkg::tri_t right_nbr;
        logic          cell_active;
        logic          cell_sel;

        if (c == 0)
        begin : g_first
            assign left_nbr = cell_tri[last_col];
        end
        else
        begin : g_inner
            assign left_nbr = cell_tri[c-1];
        end

        if (c == tlg_pkg::MAX_COLS - 1)
        begin : g_end
            assign right_nbr = cell_tri[0];
        end
        else
        begin : g_mid
            assign right_nbr = (int'(last_col) == c) ? cell_tri[0] : cell_tri[c+1];
        end

        assign cell_active = (c < int'(nc));
        assign cell_sel    = (int'(tcol_reg) == c);
        assign cur_vec[c]  = cell_tri[c].cur;

        tlg_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (ctl),
            .active (cell_active),
            .sel    (cell_sel),
            .nbr_l  (left_nbr),
            .nbr_r  (right_nbr),
            .own    (cell_tri[c])
        );
    end

    // Sequencer: next state, cell controls and result capture.
    always_comb
    begin
        state_next       = state_reg;
        head_next        = (int'(head_reg) == tlg_pkg::MAX_ROWS - 1) ? '0 : head_reg + 1'b1;
        op_next          = op_reg;
        row_next         = row_reg;
        tcol_next        = tcol_reg;
        val_next         = val_reg;
        started_next     = started_reg;
        res_alive_next   = res_alive_reg;
        res_done_next    = res_done_reg;
        out_valid_next   = out_valid_reg && out_stall;
        alive_next       = alive_reg;
        done_next        = done_reg;
        rows_in_use_next = rows_in_use_reg;
        cols_in_use_next = cols_in_use_reg;

        ctl            = '0;
        ctl.wr_val     = val_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                tlg_pkg::CFG_ROWS: rows_in_use_next = cfg_data;
                tlg_pkg::CFG_COLS: cols_in_use_next = cfg_data;
                default:           rows_in_use_next = rows_in_use_reg;
            endcase
        end

        case (state_reg)
            tlg_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next        = func;
                    row_next       = row;
                    tcol_next      = col;
                    val_next       = value;
                    res_alive_next = 1'b0;
                    res_done_next  = 1'b1;
                    case (func)
                        tlg_pkg::FUNC_WRITE,
                        tlg_pkg::FUNC_READ:
                        begin
                            state_next = in_area ? tlg_pkg::S_SEEK : tlg_pkg::S_FINISH;
                        end
                        tlg_pkg::FUNC_STEP:
                        begin
                            state_next = tlg_pkg::S_UPROW;
                        end
                        default:
                        begin
                            res_done_next = 1'b0;
                            state_next    = tlg_pkg::S_FINISH;
                        end
                    endcase
                end
            end
            tlg_pkg::S_SEEK:
            begin
                // The addressed row is at the head this cycle.
                if (at_target)
                begin
                    ctl.wr_en = (op_reg == tlg_pkg::FUNC_WRITE);
                    if (op_reg == tlg_pkg::FUNC_READ)
                    begin
                        res_alive_next = cur_vec[tcol_reg];
                    end
                    state_next = tlg_pkg::S_FINISH;
                end
            end
            tlg_pkg::S_UPROW:
            begin
                // Save the old last active row as the row above row 0.
                if (at_last_row)
                begin
                    ctl.load_up  = 1'b1;
                    started_next = 1'b0;
                    state_next   = tlg_pkg::S_GEN;
                end
            end
            tlg_pkg::S_GEN:
            begin
                if (proc)
                begin
                    ctl.update     = 1'b1;
                    ctl.load_up    = 1'b1;
                    ctl.load_first = at_row0;
                    ctl.down_first = at_last_row && !at_row0;
                    ctl.down_cur   = at_last_row && at_row0;
                    started_next   = 1'b1;
                    if (at_last_row)
                    begin
                        state_next = tlg_pkg::S_FINISH;
                    end
                end
            end
            tlg_pkg::S_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    alive_next     = res_alive_reg;
                    done_next      = res_done_reg;
                    state_next     = tlg_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tlg_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tlg_pkg::S_IDLE;
            head_reg        <= '0;
            started_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            rows_in_use_reg <= tlg_pkg::CFG_W'(64);
            cols_in_use_reg <= tlg_pkg::CFG_W'(64);
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            started_reg     <= started_next;
            out_valid_reg   <= out_valid_next;
            rows_in_use_reg <= rows_in_use_next;
            cols_in_use_reg <= cols_in_use_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        row_reg       <= row_next;
        tcol_reg      <= tcol_next;
        val_reg       <= val_next;
        res_alive_reg <= res_alive_next;
        res_done_reg  <= res_done_next;
        alive_reg     <= alive_next;
        done_reg      <= done_next;
    end

endmodule

>>> hdl/tlg_checker.sv
`include "toroidal_life_generation_top_macros.svh"

// Port-level checks for the life block.
module tlg_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic [tlg_pkg::FUNC_W-1:0] func,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic                       alive,
    input logic                       done_res
);

    // A held result keeps its payload.
    `TLG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(alive) && $stable(done_res), "result changed while stalled")

    // Every accepted item keeps the block busy in the following cycle.
    `TLG_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken again right after an accept")

    // An unused operation code accepted with a free output is answered with done_res low.
    `TLG_ASSERT_IMPL(a_unused_code, in_valid && !in_stall && (func == tlg_pkg::FUNC_NONE) && !out_valid, ##2 (out_valid && !done_res), "unused code not answered as expected")

    // An item that did not complete never reports a live cell.
    `TLG_ASSERT_IMPL(a_alive_needs_done, out_valid && !done_res, !alive, "alive set on an incomplete item")

endmodule

bind toroidal_life_generation_top tlg_checker u_tlg_checker (.*);

>>> test/life_grid_checker.sv
module life_grid_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [tlg_pkg::FUNC_W-1:0]   func,
    input  logic [tlg_pkg::ROW_W-1:0]    row,
    input  logic [tlg_pkg::COL_W-1:0]    col,
    input  logic                         value,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic                         alive,
    input  logic                         done_res,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [tlg_pkg::CFG_W-1:0]    cfg_data,
    output int                           errors,
    output int                           pending
);

    typedef struct packed {
        logic alive;
        logic done_res;
    } life_result_t;

    bit                        grid_cells [tlg_pkg::MAX_ROWS][tlg_pkg::MAX_COLS];
    bit [tlg_pkg::CFG_W-1:0]   rows_reg;
    bit [tlg_pkg::CFG_W-1:0]   cols_reg;
    life_result_t              awaited_results [$];
    life_result_t              want;
    life_result_t              fresh;
    int                        shown;

    // A size register of zero acts as one, and anything past the grid is clipped.
    function automatic int active_span(input bit [tlg_pkg::CFG_W-1:0] reg_val,
                                       input int limit);
        int span;
        span = int'(reg_val);
        if (span == 0) span = 1;
        if (span > limit) span = limit;
        return span;
    endfunction

    // Every neighbor is taken from the old generation; on one or two rows or columns
    // the wrapped positions may land on the same cell, even the cell itself.
    function automatic void next_generation();
        bit old_cells [tlg_pkg::MAX_ROWS][tlg_pkg::MAX_COLS];
        int nr, nc, n;
        old_cells = grid_cells;
        nr = active_span(rows_reg, tlg_pkg::MAX_ROWS);
        nc = active_span(cols_reg, tlg_pkg::MAX_COLS);
        for (int i = 0; i < nr; i++)
        begin
            for (int j = 0; j < nc; j++)
            begin
                n = 0;
                for (int di = -1; di <= 1; di++)
                begin
                    for (int dj = -1; dj <= 1; dj++)
                    begin
                        if (di != 0 || dj != 0)
                        begin
                            n += int'(old_cells[(i + di + nr) % nr][(j + dj + nc) % nc]);
                        end
                    end
                end
                if (old_cells[i][j])
                begin
                    grid_cells[i][j] = (n == 2 || n == 3);
                end
                else
                begin
                    grid_cells[i][j] = (n == 3);
                end
            end
        end
    endfunction

    function automatic life_result_t predict_item_result(
        input logic [tlg_pkg::FUNC_W-1:0] f,
        input logic [tlg_pkg::ROW_W-1:0]  r,
        input logic [tlg_pkg::COL_W-1:0]  c,
        input logic                       v);
        life_result_t res;
        bit in_area;
        in_area = (int'(r) < active_span(rows_reg, tlg_pkg::MAX_ROWS))
               && (int'(c) < active_span(cols_reg, tlg_pkg::MAX_COLS));
        res.alive    = 1'b0;
        res.done_res = 1'b1;
        case (f)
            tlg_pkg::FUNC_WRITE: if (in_area) grid_cells[r][c] = v;
            tlg_pkg::FUNC_READ:  if (in_area) res.alive = grid_cells[r][c];
            tlg_pkg::FUNC_STEP:  next_generation();
            default:             res.done_res = 1'b0;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tlg_pkg::MAX_ROWS; i++)
            begin
                for (int j = 0; j < tlg_pkg::MAX_COLS; j++)
                begin
                    grid_cells[i][j] = 1'b0;
                end
            end
            rows_reg = tlg_pkg::CFG_W'(64);
            cols_reg = tlg_pkg::CFG_W'(64);
            awaited_results.delete();
            errors  = 0;
            shown   = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == tlg_pkg::CFG_ROWS) rows_reg = cfg_data;
                else cols_reg = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                fresh = predict_item_result(func, row, col, value);
                awaited_results = {awaited_results, fresh};
            end
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    errors++;
                    if (shown < 10)
                    begin
                        shown++;
                        $display("%0t: result with nothing awaited: alive=%b done_res=%b",
                                 $time, alive, done_res);
                    end
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (alive !== want.alive || done_res !== want.done_res)
                    begin
                        errors++;
                        if (shown < 10)
                        begin
                            shown++;
                            $display("%0t: result mismatch: expected alive=%b done_res=%b,",
                                     $time, want.alive, want.done_res);
                            $display("    got alive=%b done_res=%b", alive, done_res);
                        end
                    end
                end
            end
            pending <= awaited_results.size();
        end
    end

endmodule

>>> test/tb.sv
module tb;

    // Upper bound on the run, far beyond the slowest legal run of this stimulus.
    localparam int CYCLE_LIMIT      = 300000;
    // The receiver holds off once for a long stretch after this many results.
    localparam int LONG_HOLD_AFTER  = 40;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS      = 15;
    localparam int DRAIN_CYCLES     = 250;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic                         in_stall;
    logic [tlg_pkg::FUNC_W-1:0]   func      = tlg_pkg::FUNC_WRITE;
    logic [tlg_pkg::ROW_W-1:0]    row       = '0;
    logic [tlg_pkg::COL_W-1:0]    col       = '0;
    logic                         value     = 1'b0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic                         alive;
    logic                         done_res;
    logic                         cfg_we    = 1'b0;
    logic                         cfg_index = tlg_pkg::CFG_ROWS;
    logic [tlg_pkg::CFG_W-1:0]    cfg_data  = '0;

    int errors;
    int pending;
    int cycle_count;
    // When set, neither side idles; the last phase of the run is driven this way.
    bit calm;
    // Chance in percent that the sender idles before an item; changes per phase.
    int gap_pct;
    // Active grid size as the block sees it, used to aim cells at the live area.
    int eff_rows = 64;
    int eff_cols = 64;

    toroidal_life_generation_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .row       (row),
        .col       (col),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .alive     (alive),
        .done_res  (done_res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // The checker watches both channels and the register port, keeps its own copy of
    // the grid, and reports how many results are still awaited and how many failed.
    life_grid_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .row       (row),
        .col       (col),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .alive     (alive),
        .done_res  (done_res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always #10 clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[toroidal_life_generation_top] ERROR");
            $finish;
        end
    end

    // Offers one item and returns at the edge where it is taken. The valid line is
    // lowered only when an idle burst is inserted, so a back-to-back item never sees
    // valid dropped and raised within the same time step.
    task automatic send(input logic [tlg_pkg::FUNC_W-1:0] f,
                        input logic [tlg_pkg::ROW_W-1:0] r,
                        input logic [tlg_pkg::COL_W-1:0] c, input logic v);
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        row      <= r;
        col      <= c;
        value    <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Registers change only while the block is idle, so the sender first waits until
    // every awaited result has come back. Both size registers are then written one
    // after the other, rows first.
    task automatic resize(input int rows_val, input int cols_val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= tlg_pkg::CFG_ROWS;
        cfg_data  <= tlg_pkg::CFG_W'(rows_val);
        @(posedge clk);
        cfg_index <= tlg_pkg::CFG_COLS;
        cfg_data  <= tlg_pkg::CFG_W'(cols_val);
        @(posedge clk);
        cfg_we   <= 1'b0;
        eff_rows = (rows_val == 0) ? 1 :
                   ((rows_val > tlg_pkg::MAX_ROWS) ? tlg_pkg::MAX_ROWS : rows_val);
        eff_cols = (cols_val == 0) ? 1 :
                   ((cols_val > tlg_pkg::MAX_COLS) ? tlg_pkg::MAX_COLS : cols_val);
    endtask

    // Picks a row or column index. Most picks land in a small window that straddles
    // the wrap boundary, so patterns on big grids still interact across the edge;
    // the rest are anywhere in the index range, outside the active area included.
    function automatic logic [5:0] pick_index(input int span);
        int k;
        if ($urandom_range(0, 99) < 12)
        begin
            k = $urandom_range(0, 63);
        end
        else if (span <= 5)
        begin
            k = $urandom_range(0, span - 1);
        end
        else
        begin
            k = (span - 2 + $urandom_range(0, 4)) % span;
        end
        return 6'(k);
    endfunction

    // One random phase on one grid size: seeding writes, generation steps and reads
    // mixed, with the occasional unused operation code.
    task automatic life_phase(input int rows_val, input int cols_val);
        int k;
        int pick;
        resize(rows_val, cols_val);
        case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 15;
            default: gap_pct = 40;
        endcase
        for (k = 0; k < PHASE_ITEMS; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 38)
            begin
                send(tlg_pkg::FUNC_WRITE, pick_index(eff_rows), pick_index(eff_cols),
                     $urandom_range(0, 99) < 60);
            end
            else if (pick < 78)
            begin
                send(tlg_pkg::FUNC_READ, pick_index(eff_rows), pick_index(eff_cols),
                     1'($urandom));
            end
            else if (pick < 92)
            begin
                send(tlg_pkg::FUNC_STEP, 6'($urandom), 6'($urandom), 1'($urandom));
            end
            else
            begin
                send(tlg_pkg::FUNC_NONE, 6'($urandom), 6'($urandom), 1'($urandom));
            end
        end
    endtask

    // Result side. The stall rate is redrawn now and then, so there are stretches with
    // no stalls at all. Once, after a fixed number of results, the receiver stops
    // taking results for a long stretch while the sender keeps offering items, so the
    // output register fills and the block stalls its input.
    initial
    begin : result_sink
        int  results_taken;
        int  stall_pct;
        bit  long_hold_done;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall) results_taken++;
            if ($urandom_range(0, 63) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 10;
                    default: stall_pct = 30;
                endcase
            end
            if (!long_hold_done && results_taken >= LONG_HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < stall_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : stimulus
        gap_pct = 25;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full 64 by 64 grid after reset. Three cells around the corner form an L
        // across both wrap edges; one step gives birth to the fourth corner cell.
        send(tlg_pkg::FUNC_WRITE, 6'd63, 6'd63, 1'b1);
        send(tlg_pkg::FUNC_WRITE, 6'd0,  6'd0,  1'b1);
        send(tlg_pkg::FUNC_WRITE, 6'd0,  6'd63, 1'b1);
        send(tlg_pkg::FUNC_READ,  6'd63, 6'd63, 1'b0);
        send(tlg_pkg::FUNC_READ,  6'd31, 6'd17, 1'b1);
        // The unused code changes nothing and answers with done_res low.
        send(tlg_pkg::FUNC_NONE,  6'd42, 6'd21, 1'b1);
        send(tlg_pkg::FUNC_STEP,  6'd0,  6'd0,  1'b0);
        send(tlg_pkg::FUNC_READ,  6'd63, 6'd0,  1'b0);
        send(tlg_pkg::FUNC_READ,  6'd0,  6'd0,  1'b0);

        // Zero in both registers acts as a single cell. That cell sees itself as all
        // eight neighbors, so it dies on the next step. Cells beyond it are ignored
        // by writes and read as dead.
        resize(0, 0);
        send(tlg_pkg::FUNC_WRITE, 6'd0,  6'd0,  1'b1);
        send(tlg_pkg::FUNC_STEP,  6'd63, 6'd63, 1'b1);
        send(tlg_pkg::FUNC_READ,  6'd0,  6'd0,  1'b0);
        send(tlg_pkg::FUNC_WRITE, 6'd0,  6'd1,  1'b1);
        send(tlg_pkg::FUNC_READ,  6'd0,  6'd1,  1'b0);

        // Rows saturate at the grid height; only two columns, so left and right
        // neighbors are the same cell. Column 63 keeps its old contents through the
        // step, and a read of it outside the active area returns a dead cell.
        resize(127, 2);
        send(tlg_pkg::FUNC_WRITE, 6'd5,  6'd0,  1'b1);
        send(tlg_pkg::FUNC_WRITE, 6'd5,  6'd1,  1'b1);
        send(tlg_pkg::FUNC_WRITE, 6'd6,  6'd0,  1'b1);
        send(tlg_pkg::FUNC_STEP,  6'd0,  6'd0,  1'b0);
        send(tlg_pkg::FUNC_READ,  6'd5,  6'd0,  1'b0);
        send(tlg_pkg::FUNC_READ,  6'd4,  6'd1,  1'b0);
        send(tlg_pkg::FUNC_READ,  6'd6,  6'd1,  1'b0);
        send(tlg_pkg::FUNC_READ,  6'd63, 6'd63, 1'b0);

        // Random phases over a spread of grid sizes, the full grid among them.
        life_phase(3, 3);
        life_phase(4, 5);
        life_phase(1, 6);
        life_phase(64, 64);
        life_phase(6, 2);
        life_phase(2, 1);
        life_phase($urandom_range(0, 127), $urandom_range(0, 127));
        calm = 1'b1;
        life_phase(5, 7);

        // Wait for the last results, then a quiet stretch to catch stray ones.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("[toroidal_life_generation_top] OK");
        end
        else
        begin
            $display("[toroidal_life_generation_top] ERROR");
        end
        $finish;
    end

endmodule

>>> toroidal_life_generation_top.f
+incdir+hdl
hdl/tlg_pkg.sv
hdl/tlg_cell.sv
hdl/toroidal_life_generation_top.sv
hdl/tlg_checker.sv
test/life_grid_checker.sv
test/tb.sv
